@@ sv/ubx_nmea_stream_deframer_top_macros.svh @@
// assertion macros for the deframer checker
// expects clk and rst in the scope of use
`ifndef UBX_NMEA_STREAM_DEFRAMER_TOP_MACROS_SVH
`define UBX_NMEA_STREAM_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define UNSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define UNSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ sv/unsd_pkg.sv @@
// shared types and constants for the binary/text stream deframer
// no dependencies
package unsd_pkg;

  localparam int TEXT_CAPACITY_DEF = 128;
  localparam int BIN_CAPACITY_DEF  = 1024;

  localparam int CFG_IDX_W  = 8;
  localparam int BIN_CNT_W  = 17;
  localparam int TEXT_CNT_W = 8;

  localparam logic [BIN_CNT_W-1:0] HDR_BYTES   = 17'd6;
  localparam logic [BIN_CNT_W-1:0] CSUM_BYTES  = 17'd2;
  localparam logic [BIN_CNT_W-1:0] LEN_LOW_POS = 17'd4;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;
  localparam logic [7:0] START_CHAR_RST  = 8'd36;
  localparam logic [7:0] END_CHAR_RST    = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 8'd0,
    CFG_SYNC_SECOND = 8'd1,
    CFG_START_CHAR  = 8'd2,
    CFG_END_CHAR    = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] start_char;
    logic [7:0] end_char;
  } cfg_t;

  typedef struct packed {
    logic        store;
    logic        abort;
    logic        done;
    logic [15:0] length;
    logic        overflow;
    logic        hidden;
  } bin_tags_t;

  typedef struct packed {
    logic store;
    logic abort;
    logic done;
    logic overflow;
  } text_tags_t;

endpackage

@@ sv/unsd_byte_if.sv @@
// input byte channel: valid, ready and one received byte
// no dependencies
interface unsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ sv/unsd_res_if.sv @@
// result channel: valid, ready and the tags of one byte
// no dependencies
interface unsd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        bin_store;
  logic        bin_abort;
  logic        bin_done;
  logic [15:0] bin_length;
  logic        bin_overflow;
  logic        text_store;
  logic        text_abort;
  logic        text_done;
  logic        text_overflow;

  modport source (
    output valid, output byte_out, output bin_store, output bin_abort, output bin_done,
    output bin_length, output bin_overflow, output text_store, output text_abort,
    output text_done, output text_overflow, input ready
  );
  modport sink (
    input valid, input byte_out, input bin_store, input bin_abort, input bin_done,
    input bin_length, input bin_overflow, input text_store, input text_abort,
    input text_done, input text_overflow, output ready
  );
endinterface

@@ sv/unsd_cfg_if.sv @@
// configuration write channel: valid, ready, register index and data
// depends on unsd_pkg for the index width
interface unsd_cfg_if
  import unsd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/unsd_cfg_regs.sv @@
// configuration register file for sync and framing characters
// depends on unsd_pkg and unsd_cfg_if
module unsd_cfg_regs
  import unsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  unsd_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_first  <= SYNC_FIRST_RST;
      regs.sync_second <= SYNC_SECOND_RST;
      regs.start_char  <= START_CHAR_RST;
      regs.end_char    <= END_CHAR_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_SYNC_FIRST:  regs.sync_first  <= cfg.data;
        CFG_SYNC_SECOND: regs.sync_second <= cfg.data;
        CFG_START_CHAR:  regs.start_char  <= cfg.data;
        CFG_END_CHAR:    regs.end_char    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/unsd_bin_track.sv @@
// binary frame tracker: sync pair, header, length and frame end counting
// depends on unsd_pkg
module unsd_bin_track
  import unsd_pkg::*;
#(
  parameter int BIN_CAPACITY = BIN_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output bin_tags_t  tags
);

  typedef enum logic [1:0] {
    BP_READY = 2'd0,
    BP_SYNC  = 2'd1,
    BP_LEN   = 2'd2,
    BP_DATA  = 2'd3
  } bin_phase_t;

  localparam logic [BIN_CNT_W-1:0] BinCap = BIN_CNT_W'(BIN_CAPACITY);

  bin_phase_t           phase, phase_next;
  logic [BIN_CNT_W-1:0] count, count_next;
  logic [7:0]           len_low, len_low_next;
  logic [15:0]          len, len_next;
  logic [BIN_CNT_W-1:0] count_inc;
  logic [BIN_CNT_W-1:0] frame_end;
  logic                 over;

  assign count_inc = count + 1'b1;
  assign frame_end = HDR_BYTES + {1'b0, len} + CSUM_BYTES;
  assign over      = (count >= BinCap);

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    len_low_next = len_low;
    len_next     = len;
    tags         = '0;
    unique case (phase)
      BP_READY: begin
        if (data_byte == cfg.sync_first) begin
          tags.store    = 1'b1;
          tags.overflow = over;
          count_next    = BIN_CNT_W'(1);
          phase_next    = BP_SYNC;
        end
      end
      BP_SYNC: begin
        if (data_byte == cfg.sync_second) begin
          tags.store    = 1'b1;
          tags.overflow = over;
          tags.hidden   = 1'b1;
          count_next    = BIN_CNT_W'(2);
          phase_next    = BP_LEN;
        end else begin
          tags.abort = 1'b1;
          count_next = '0;
          phase_next = BP_READY;
        end
      end
      BP_LEN: begin
        tags.store    = 1'b1;
        tags.overflow = over;
        tags.hidden   = 1'b1;
        if (count == LEN_LOW_POS) len_low_next = data_byte;
        count_next = count_inc;
        if (count_inc >= HDR_BYTES) begin
          len_next   = {data_byte, len_low};
          phase_next = BP_DATA;
        end
      end
      BP_DATA: begin
        tags.store    = 1'b1;
        tags.overflow = over;
        tags.hidden   = 1'b1;
        count_next    = count_inc;
        if (count_inc >= frame_end) begin
          tags.done   = 1'b1;
          tags.length = len;
          count_next  = '0;
          phase_next  = BP_READY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= BP_READY;
      count   <= '0;
      len_low <= '0;
      len     <= '0;
    end else if (step) begin
      phase   <= phase_next;
      count   <= count_next;
      len_low <= len_low_next;
      len     <= len_next;
    end
  end

endmodule

@@ sv/unsd_text_track.sv @@
// text sentence tracker: start character, abort on binary sync, terminator
// depends on unsd_pkg
module unsd_text_track
  import unsd_pkg::*;
#(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       hidden,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output text_tags_t tags
);

  typedef enum logic [1:0] {
    TP_READY = 2'd0,
    TP_SYNC  = 2'd1,
    TP_DATA  = 2'd2
  } text_phase_t;

  localparam logic [TEXT_CNT_W-1:0] TextCap = TEXT_CNT_W'(TEXT_CAPACITY);

  text_phase_t           phase, phase_next;
  logic [TEXT_CNT_W-1:0] count, count_next;
  logic                  full;

  assign full = (count >= TextCap);

  always_comb begin
    phase_next = phase;
    count_next = count;
    tags       = '0;
    if (!hidden) begin
      unique case (phase)
        TP_SYNC: begin
          if (data_byte != cfg.sync_second) begin
            tags.overflow = full;
            tags.store    = !full;
            if (!full) count_next = count + 1'b1;
            phase_next = TP_DATA;
          end else begin
            tags.abort = 1'b1;
            count_next = '0;
            phase_next = TP_READY;
          end
        end
        TP_DATA: begin
          if (data_byte == cfg.end_char) begin
            tags.done  = 1'b1;
            count_next = '0;
            phase_next = TP_READY;
          end else begin
            tags.overflow = full;
            tags.store    = !full;
            if (!full) count_next = count + 1'b1;
          end
        end
        default: begin
          phase_next = TP_READY;
          if (data_byte == cfg.start_char) begin
            // the start character is stored unchecked; the user must keep capacity at least eight, not enforced here
            tags.store = 1'b1;
            count_next = TEXT_CNT_W'(1);
            phase_next = TP_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TP_READY;
      count <= '0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

@@ sv/ubx_nmea_stream_deframer_top.sv @@
// top level of the mixed binary/text stream deframer
// depends on unsd_pkg, the channel interfaces, unsd_cfg_regs and both trackers
//
// usage
//   rx carries one received byte per transaction; tags returns one result per
//   byte with the byte itself and its binary and text framing tags.
//   cfg writes the four framing characters (index 0 to 3, others ignored);
//   cfg.ready is always high and writes are meant for an idle block.
// pipeline and throughput
//   a byte accepted on rx is registered in s0, classified by both trackers and
//   its result is registered onto tags. one byte per cycle is sustained while
//   tags.ready stays high; the limit is the tracker state update.
// reset
//   rst is synchronous; both trackers return to waiting, counts clear, the
//   framing characters return to their defaults and both channels go empty.
// stalls
//   while tags.ready is low the result holds and one more byte is taken into
//   the input register; rx.ready then drops until the result is taken.
module ubx_nmea_stream_deframer_top
  import unsd_pkg::*;
#(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  parameter int BIN_CAPACITY  = BIN_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  unsd_byte_if.sink   rx,
  unsd_res_if.source  tags,
  unsd_cfg_if.sink    cfg
);

  cfg_t       regs;
  bin_tags_t  btags;
  text_tags_t ttags;

  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       advance;
  logic       step;

  assign advance  = !tags.valid || tags.ready;
  assign rx.ready = !s0_valid || advance;
  assign step     = s0_valid && advance;

  unsd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  unsd_bin_track #(
    .BIN_CAPACITY (BIN_CAPACITY)
  ) u_bin (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s0_byte),
    .cfg       (regs),
    .tags      (btags)
  );

  unsd_text_track #(
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_text (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .hidden    (btags.hidden),
    .data_byte (s0_byte),
    .cfg       (regs),
    .tags      (ttags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      tags.valid <= 1'b0;
    end else begin
      if (rx.ready) s0_valid <= rx.valid;
      if (advance) tags.valid <= s0_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) s0_byte <= rx.data_byte;
    if (step) begin
      tags.byte_out      <= s0_byte;
      tags.bin_store     <= btags.store;
      tags.bin_abort     <= btags.abort;
      tags.bin_done      <= btags.done;
      tags.bin_length    <= btags.length;
      tags.bin_overflow  <= btags.overflow;
      tags.text_store    <= ttags.store;
      tags.text_abort    <= ttags.abort;
      tags.text_done     <= ttags.done;
      tags.text_overflow <= ttags.overflow;
    end
  end

endmodule

@@ sv/unsd_checker.sv @@
// port-level checker for the deframer top level, with its bind statement
// depends on ubx_nmea_stream_deframer_top_macros.svh
`include "ubx_nmea_stream_deframer_top_macros.svh"

module unsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_out,
  input logic        bin_store,
  input logic        bin_abort,
  input logic        bin_done,
  input logic [15:0] bin_length,
  input logic        text_store,
  input logic        text_overflow
);

  `UNSD_ASSERT_IMP(a_done_stored, out_valid && bin_done, bin_store)
  `UNSD_ASSERT_IMP(a_len_only_at_done, out_valid && !bin_done, bin_length == 16'd0)
  `UNSD_ASSERT_IMP(a_abort_alone, out_valid && bin_abort, !bin_store && !bin_done)
  `UNSD_ASSERT_IMP(a_text_excl, out_valid, !(text_store && text_overflow))
  `UNSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(byte_out))

endmodule

bind ubx_nmea_stream_deframer_top unsd_checker u_unsd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (tags.valid),
  .out_ready     (tags.ready),
  .byte_out      (tags.byte_out),
  .bin_store     (tags.bin_store),
  .bin_abort     (tags.bin_abort),
  .bin_done      (tags.bin_done),
  .bin_length    (tags.bin_length),
  .text_store    (tags.text_store),
  .text_overflow (tags.text_overflow)
);
